FILE: src/sha256_pkg.sv
// Package with SHA-256 constants, round-constant table, initial hash values and a rotate function.
`default_nettype none
package sha256_pkg;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        begin
            unique case (idx)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
                6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
                6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
                6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
                6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
                6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
                6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
                6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
                6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
                6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
                6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
                default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] initial_hash(input logic [2:0] idx);
        logic [31:0] h;
        begin
            unique case (idx)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

FILE: src/sha256_round.sv
// One SHA-256 compression round on the working variables.
`default_nettype none
module sha256_round
(
    input  wire logic [255:0] vars,
    input  wire logic [31:0]  k,
    input  wire logic [31:0]  w,
    output logic      [255:0] vars_out
);
    import sha256_pkg::*;

    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2;

    always_comb
    begin
        {a, b, c, d, e, f, g, h} = vars;
        t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g)) + k + w;
        t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        vars_out = {t1 + t2, a, b, c, d + t1, e, f, g};
    end

endmodule
`default_nettype wire

FILE: src/sha256_stream_hash.sv
// Top level of the byte-stream SHA-256 engine.
`default_nettype none
// An absorb word is taken while the engine is idle; its byte is merged into a
// word register and each full word lands in a 16x32 block memory with a
// registered read port. When the 64th byte of a block lands, the input stalls
// while the block is read into the 16-entry schedule ring, the rounds run, and
// the working variables are folded into the eight chaining registers. A finish
// word with n bytes buffered writes the padding one byte per cycle and then
// compresses the block; when n is 56 or more, a second block of padding is
// written and compressed. The eight digest words then leave h0 first, one per
// cycle in which the sink does not stall, and the input stays stalled until the
// last one is taken.
module sha256_stream_hash
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [31:0] digest_word,
    output logic      [2:0]  word_index,
    output logic             last_word
);
    import sha256_pkg::*;

    // Block memory of 32-bit big-endian words; bytes merged in a word register.
    logic [31:0] chain_reg [8];
    logic [31:0] wring_reg [16];
    logic [31:0] blk_mem [16];

    state_t      state_reg, state_next;
    logic [5:0]  nbytes_reg, nbytes_next;
    logic [63:0] bits_reg, bits_next;
    logic [63:0] plen_reg, plen_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        finishing_reg, finishing_next;
    logic        pad_len_reg, pad_len_next;
    logic [31:0] acc_reg, acc_next;
    logic [255:0] vars_reg, vars_next, round_out;
    logic [31:0] wcur;
    logic [31:0] blk_rd_reg;
    logic        blk_we;
    logic [3:0]  blk_wa;
    logic [31:0] blk_wd;
    logic [3:0]  blk_ra;
    logic        push;
    logic [7:0]  push_byte;
    logic [7:0]  byte_in;
    logic        chain_init;
    logic        chain_fold;
    logic [31:0] w15, w2, s0, s1;

    sha256_round u_round
    (
        .vars     (vars_reg),
        .k        (round_k(cnt_reg[5:0])),
        .w        (wcur),
        .vars_out (round_out)
    );

    assign w15 = wring_reg[1];
    assign w2  = wring_reg[14];
    assign s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
    assign s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
    assign wcur = (cnt_reg < 7'd16) ? wring_reg[0] : wring_reg[0] + s0 + wring_reg[9] + s1;

    // The length goes into the last eight bytes only of the block that holds the mark
    // below byte 56 or that follows a block whose mark sat too late.
    always_comb
    begin
        if (cnt_reg == 7'd0)
            push_byte = PAD_MARK;
        else if (pad_len_reg && nbytes_reg >= LEN_POS)
            push_byte = plen_reg[{~nbytes_reg[2:0], 3'b000} +: 8];
        else
            push_byte = 8'h00;
    end

    assign byte_in = (state_reg == ST_IDLE) ? data_byte : push_byte;

    always_comb
    begin
        state_next     = state_reg;
        nbytes_next    = nbytes_reg;
        bits_next      = bits_reg;
        plen_next      = plen_reg;
        cnt_next       = cnt_reg;
        finishing_next = finishing_reg;
        pad_len_next   = pad_len_reg;
        acc_next       = acc_reg;
        vars_next      = vars_reg;
        push           = 1'b0;
        chain_init     = 1'b0;
        chain_fold     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_ABSORB)
                    begin
                        push      = 1'b1;
                        bits_next = bits_reg + 64'd8;
                    end
                    else
                    begin
                        plen_next      = bits_reg;
                        finishing_next = 1'b1;
                        pad_len_next   = 1'b0;
                        cnt_next       = 7'd0;
                        state_next     = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push     = 1'b1;
                cnt_next = 7'd1;
                if (nbytes_reg < LEN_POS)
                    pad_len_next = 1'b1;
            end
            ST_LOAD:
            begin
                // The read issued at count c returns at count c + 1.
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd16)
                begin
                    cnt_next   = 7'd0;
                    vars_next  = {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3],
                                  chain_reg[4], chain_reg[5], chain_reg[6], chain_reg[7]};
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                vars_next = round_out;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    cnt_next   = 7'd0;
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                chain_fold = 1'b1;
                cnt_next   = 7'd0;
                if (!finishing_reg)
                    state_next = ST_IDLE;
                else if (pad_len_reg)
                    state_next = ST_EMIT;
                else
                begin
                    cnt_next   = 7'd1;
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd7)
                    begin
                        chain_init     = 1'b1;
                        bits_next      = 64'd0;
                        nbytes_next    = 6'd0;
                        finishing_next = 1'b0;
                        pad_len_next   = 1'b0;
                        cnt_next       = 7'd0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push)
        begin
            acc_next    = {acc_reg[23:0], byte_in};
            nbytes_next = nbytes_reg + 6'd1;
            if (nbytes_reg == 6'd63)
            begin
                cnt_next   = 7'd0;
                state_next = ST_LOAD;
            end
        end
    end

    // The input stalls while the block is read, so no write overlaps a read.
    assign blk_we = push && (nbytes_reg[1:0] == 2'd3);
    assign blk_wa = nbytes_reg[5:2];
    assign blk_wd = {acc_reg[23:0], byte_in};
    assign blk_ra = cnt_reg[3:0];

    always_ff @(posedge clk)
    begin
        if (blk_we)
            blk_mem[blk_wa] <= blk_wd;
        blk_rd_reg <= blk_mem[blk_ra];
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        vars_reg <= vars_next;
        plen_reg <= plen_next;
        if (state_reg == ST_LOAD && cnt_reg != 7'd0)
        begin
            for (int i = 0; i < 15; i++)
                wring_reg[i] <= wring_reg[i + 1];
            wring_reg[15] <= blk_rd_reg;
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                wring_reg[i] <= wring_reg[i + 1];
            wring_reg[15] <= wcur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nbytes_reg    <= 6'd0;
            bits_reg      <= 64'd0;
            cnt_reg       <= 7'd0;
            finishing_reg <= 1'b0;
            pad_len_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= initial_hash(3'(i));
        end
        else
        begin
            state_reg     <= state_next;
            nbytes_reg    <= nbytes_next;
            bits_reg      <= bits_next;
            cnt_reg       <= cnt_next;
            finishing_reg <= finishing_next;
            pad_len_reg   <= pad_len_next;
            if (chain_init)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= initial_hash(3'(i));
            end
            else if (chain_fold)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + vars_reg[255 - 32 * i -: 32];
            end
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_EMIT);
    assign digest_word = chain_reg[cnt_reg[2:0]];
    assign word_index  = cnt_reg[2:0];
    assign last_word   = (cnt_reg[2:0] == 3'd7);

endmodule
`default_nettype wire

FILE: tb/sha256_stream_hash_test.sv
// Testbench for the byte-stream SHA-256 engine, checked against its own digest predictor.
`default_nettype none

class digest_scoreboard;
    localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] msg_bits;
    logic [31:0] digest_q[$];
    int          errors;
    int          digests;

    function new();
        errors = 0;
        digests = 0;
        restart();
    endfunction

    function void restart();
        chain = IV;
        fill = 0;
        msg_bits = '0;
    endfunction

    function logic [31:0] rr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
        v = chain;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += v[i];
    endfunction

    function void append(logic [7:0] b);
        blk[fill] = b;
        fill++;
        if (fill == 64)
        begin
            compress();
            fill = 0;
        end
    endfunction

    function void note_word(logic cmd, logic [7:0] b);
        logic [63:0] len;
        if (!cmd)
        begin
            msg_bits += 64'd8;
            append(b);
            return;
        end
        len = msg_bits;
        append(8'h80);
        while (fill != 56)
            append(8'h00);
        for (int i = 0; i < 8; i++)
            append(len[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++)
            digest_q.push_back(chain[i]);
        digests++;
        restart();
    endfunction

    function void check_word(logic [31:0] dw, logic [2:0] idx, logic lw);
        logic [31:0] exp_w;
        logic [2:0]  exp_i;
        if (digest_q.size() == 0)
        begin
            $error("unexpected digest word %h", dw);
            errors++;
            return;
        end
        exp_i = 3'(8 - digest_q.size() % 8);
        exp_w = digest_q.pop_front();
        if (dw !== exp_w)
        begin
            $error("digest_word expected %h actual %h", exp_w, dw);
            errors++;
        end
        if (idx !== exp_i)
        begin
            $error("word_index expected %0d actual %0d", exp_i, idx);
            errors++;
        end
        if (lw !== (exp_i == 3'd7))
        begin
            $error("last_word expected %0d actual %0d", exp_i == 3'd7, lw);
            errors++;
        end
    endfunction
endclass

module sha256_stream_hash_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sha256_pkg::*;

    localparam int   IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_scoreboard sb;
    int  idle_cycles;
    int  sent;
    int  burst_left;
    int  stall_mode;

    sha256_stream_hash u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Accepted words on both sides, plus the idle watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_word(command, data_byte);
            if (out_valid && !out_stall)
                sb.check_word(digest_word, word_index, last_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver stall pattern: mode changes now and then.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Drives one word and holds it until taken; gaps come between bursts.
    task automatic send_word(logic cmd, logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        command <= cmd;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic send_message(int len, bit all_ones);
        for (int i = 0; i < len; i++)
            send_word(CMD_ABSORB, all_ones ? 8'hff : 8'($urandom_range(0, 255)));
        send_word(CMD_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.digest_q.size() != 0);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_ABSORB;
        data_byte = 8'h00;
        out_stall = 1'b0;
        stall_mode = 0;
        idle_cycles = 0;
        sent = 0;
        burst_left = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message with a nonzero finish byte, then wait for its digest.
        send_word(CMD_FINISH, 8'hff);
        drain();
        // Back-to-back finishes with no drain between them.
        send_word(CMD_FINISH, 8'h00);
        send_word(CMD_FINISH, 8'h00);
        // A full block taken by absorbing, then a tail whose padding needs a second block.
        send_message($urandom_range(120, 123), 1'b0);
        drain();
        repeat (20)
            @(posedge clk);
        $display("Ran %0d words into %0d digests: empty messages, back-to-back finishes",
                 sent, sb.digests);
        $display("and a message spanning a full block plus a two-block padding tail.");
        if (sb.errors == 0 && sb.digest_q.size() == 0)
            $display("sha256_stream_hash_test passed");
        else
            $display("sha256_stream_hash_test failed");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("sha256_stream_hash_test failed");
        $finish;
    end
endmodule
`default_nettype wire
